FILE: hw/rtl/lfsc_pkg.sv
package lfsc_pkg;

   localparam int LEVEL_W = 10;
   localparam int DRIVE_W = 11;
   localparam int TICK_W  = 6;
   localparam int PROD_W  = 20;
   localparam int CSR_IDX_W = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_SCALE = 10'd900;

   // floor(p / 900) == (p * RECIP) >> RECIP_SHIFT, exact for p < 2^20
   localparam int RECIP_W = 21;
   localparam logic [RECIP_W-1:0] RECIP = 21'd1193047;
   localparam int RECIP_SHIFT = 30;
   localparam int QPROD_W = PROD_W + RECIP_W;

   localparam logic [LEVEL_W-1:0] NOMINAL_RST   = 10'd500;
   localparam logic [LEVEL_W-1:0] MAX_SPEED_RST = 10'd1000;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 10'd600;
   localparam logic [TICK_W-1:0]  LEFT_TICKS_RST  = 6'd20;
   localparam logic [TICK_W-1:0]  RIGHT_TICKS_RST = 6'd40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOMINAL_SPEED     = 3'd0,
      CSR_MAX_SPEED         = 3'd1,
      CSR_LINE_THRESHOLD    = 3'd2,
      CSR_LEFT_SWEEP_TICKS  = 3'd3,
      CSR_RIGHT_SWEEP_TICKS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic              neg;
   } wheel_term_type;

endpackage

FILE: hw/rtl/line_follow_search_controller.sv
// Pipeline: a req transfer passes the input register, then the result register, before rsp_valid rises.
// Throughput: one tick per cycle unless rsp_stall holds the output; the sensor-term multiply
// precedes the input register, the divide-by-900 reciprocal multiply the result register.
// Reset (synchronous, active high): follow mode, left sweep phase, tick count zero,
// registers at their default values, both pipeline stages empty.
module line_follow_search_controller
   import lfsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [LEVEL_W-1:0]        csr_data,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [LEVEL_W-1:0]        req_left_level,
   input  logic [LEVEL_W-1:0]        req_center_level,
   input  logic [LEVEL_W-1:0]        req_right_level,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_left_drive,
   output logic signed [DRIVE_W-1:0] rsp_right_drive,
   output logic                      rsp_drive_valid,
   output logic                      rsp_search_active
);

   typedef enum logic [1:0] {
      PHASE_LEFT     = 2'd0,
      PHASE_RIGHT    = 2'd1,
      PHASE_STRAIGHT = 2'd2
   } phase_type;

   logic [LEVEL_W-1:0] nominal_ff, max_speed_ff, threshold_ff;
   logic [TICK_W-1:0]  left_ticks_ff, right_ticks_ff;

   logic               s1_valid_ff;
   wheel_term_type     ld_term_ff, rd_term_ff;
   logic [LEVEL_W-1:0] center_ff;
   wheel_term_type     ld_term_in, rd_term_in;

   logic               search_ff, search_in;
   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;

   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] ld_ff, rd_ff, ld_in, rd_in;
   logic                      drive_valid_ff, drive_valid_in;
   logic                      search_out_ff;

   logic out_free, s1_move, req_take;
   logic lost;
   logic signed [DRIVE_W-1:0] ld_follow, rd_follow, nom_pos, nom_neg;

   function automatic wheel_term_type make_term(input logic [LEVEL_W-1:0] nom,
                                                input logic [LEVEL_W-1:0] opp);
      wheel_term_type     t;
      logic [LEVEL_W-1:0] diff;
      begin
         if (opp <= LEVEL_SCALE) begin
            diff  = LEVEL_SCALE - opp;
            t.neg = 1'b0;
         end else begin
            diff  = opp - LEVEL_SCALE;
            t.neg = 1'b1;
         end
         t.prod = PROD_W'(nom) * PROD_W'(diff);
         return t;
      end
   endfunction

   function automatic logic signed [DRIVE_W-1:0] follow_speed(input wheel_term_type t,
                                                               input logic [LEVEL_W-1:0] lim);
      logic [QPROD_W-1:0] qp;
      logic [LEVEL_W-1:0] q, mag;
      logic [DRIVE_W-1:0] m;
      begin
         qp  = QPROD_W'(t.prod) * QPROD_W'(RECIP);
         q   = qp[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
         mag = (q > lim) ? lim : q;
         m   = {1'b0, mag};
         return t.neg ? -signed'(m) : signed'(m);
      end
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign ld_term_in = make_term(nominal_ff, req_right_level);
   assign rd_term_in = make_term(nominal_ff, req_left_level);

   assign lost      = center_ff > threshold_ff;
   assign ld_follow = follow_speed(ld_term_ff, max_speed_ff);
   assign rd_follow = follow_speed(rd_term_ff, max_speed_ff);
   assign nom_pos   = signed'({1'b0, nominal_ff});
   assign nom_neg   = -nom_pos;

   always_comb begin
      search_in      = search_ff;
      phase_in       = phase_ff;
      tick_in        = tick_ff;
      ld_in          = '0;
      rd_in          = '0;
      drive_valid_in = 1'b1;
      if (!search_ff) begin
         if (lost) begin
            search_in = 1'b1;
         end else begin
            ld_in = ld_follow;
            rd_in = rd_follow;
         end
      end else if (!lost) begin
         search_in = 1'b0;
         phase_in  = PHASE_LEFT;
         tick_in   = '0;
      end else begin
         case (phase_ff)
            PHASE_LEFT: begin
               if (tick_ff < left_ticks_ff) begin
                  ld_in   = nom_neg;
                  rd_in   = nom_pos;
                  tick_in = tick_ff + 1'b1;
               end else begin
                  tick_in        = '0;
                  phase_in       = PHASE_RIGHT;
                  drive_valid_in = 1'b0;
               end
            end
            PHASE_RIGHT: begin
               if (tick_ff < right_ticks_ff) begin
                  ld_in   = nom_pos;
                  rd_in   = nom_neg;
                  tick_in = tick_ff + 1'b1;
               end else begin
                  tick_in        = '0;
                  phase_in       = PHASE_STRAIGHT;
                  drive_valid_in = 1'b0;
               end
            end
            default: begin
               ld_in = nom_pos;
               rd_in = nom_pos;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff     <= NOMINAL_RST;
         max_speed_ff   <= MAX_SPEED_RST;
         threshold_ff   <= THRESHOLD_RST;
         left_ticks_ff  <= LEFT_TICKS_RST;
         right_ticks_ff <= RIGHT_TICKS_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_NOMINAL_SPEED:     nominal_ff     <= csr_data;
            CSR_MAX_SPEED:         max_speed_ff   <= csr_data;
            CSR_LINE_THRESHOLD:    threshold_ff   <= csr_data;
            CSR_LEFT_SWEEP_TICKS:  left_ticks_ff  <= csr_data[TICK_W-1:0];
            CSR_RIGHT_SWEEP_TICKS: right_ticks_ff <= csr_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_take) begin
         ld_term_ff <= ld_term_in;
         rd_term_ff <= rd_term_in;
         center_ff  <= req_center_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff    <= 1'b0;
         phase_ff     <= PHASE_LEFT;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            search_ff    <= search_in;
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_move) begin
         ld_ff          <= ld_in;
         rd_ff          <= rd_in;
         drive_valid_ff <= drive_valid_in;
         search_out_ff  <= search_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_drive    = ld_ff;
   assign rsp_right_drive   = rd_ff;
   assign rsp_drive_valid   = drive_valid_ff;
   assign rsp_search_active = search_out_ff;

endmodule
